// File: design/ipv4dq_pkg.sv
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, constants and field-update functions for the dotted-quad
// address validator.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

	localparam logic [7:0] DelimReset   = 8'd46;
	localparam logic [7:0] FieldMax     = 8'd255;
	localparam logic [2:0] FieldsNeeded = 3'd4;
	localparam logic [7:0] CharZero     = 8'd48;
	localparam logic [7:0] CharNine     = 8'd57;
	localparam logic [2:0] CountSat     = 3'd7;
	localparam logic [1:0] DigitSat     = 2'd2;

	// per-string scan state
	typedef struct packed {
		logic [2:0] field_count;
		logic [7:0] field_value;
		logic [1:0] digit_count;
		logic       first_digit_zero;
		logic       error_seen;
		logic [2:0] zero_fields;
		logic [2:0] full_fields;
	} dq_state_t;

	localparam dq_state_t StateClear = '{
		field_count:      3'd0,
		field_value:      8'd0,
		digit_count:      2'd0,
		first_digit_zero: 1'b0,
		error_seen:       1'b0,
		zero_fields:      3'd0,
		full_fields:      3'd0
	};

	// saturating count up to seven
	function automatic logic [2:0] sat_inc7(input logic [2:0] v);
		return (v < CountSat) ? v + 3'd1 : CountSat;
	endfunction

	// end of a field: check it, tally it, clear field state
	function automatic dq_state_t close_field(input dq_state_t s);
		dq_state_t r;
		r = s;
		if (s.digit_count == 2'd0) begin
			r.error_seen = 1'b1;
		end else begin
			if (s.field_value == 8'd0)
				r.zero_fields = sat_inc7(s.zero_fields);
			if (s.field_value == FieldMax)
				r.full_fields = sat_inc7(s.full_fields);
		end
		r.field_count      = sat_inc7(s.field_count);
		r.field_value      = 8'd0;
		r.digit_count      = 2'd0;
		r.first_digit_zero = 1'b0;
		return r;
	endfunction

	// one decimal digit into the running field value
	function automatic dq_state_t take_digit(input dq_state_t s, input logic [3:0] d);
		dq_state_t   r;
		logic [11:0] nxt;
		r = s;
		if (s.digit_count == 2'd0)
			r.first_digit_zero = (d == 4'd0);
		else if (s.first_digit_zero)
			r.error_seen = 1'b1;
		nxt = ({4'd0, s.field_value} << 3) + ({4'd0, s.field_value} << 1) + {8'd0, d};
		if (nxt > {4'd0, FieldMax}) begin
			r.field_value = FieldMax;
			r.error_seen  = 1'b1;
		end else begin
			r.field_value = nxt[7:0];
		end
		if (s.digit_count < DigitSat)
			r.digit_count = s.digit_count + 2'd1;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/ipv4_dotted_quad_validator_unit.sv
// A final character's verdict passes the stage-1 register and then the result register before it is shown.
// Throughput: one character per cycle while the input is not stalled, set by the single state-update pass.
// A character that does not end the string gives no result word.
// The input stalls only while a final character waits behind an unread verdict.
// Reset (arst_n, asynchronous) clears the scan state and sets the delimiter to '.'.
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_validator_unit
// Validates a dotted-quad address string streamed one character per word,
// giving one verdict word per string.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_dotted_quad_validator_unit
	import ipv4dq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] delimiter,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            valid_res
);

	logic       delim_q;
	logic [7:0] delim_val_q;
	logic       v_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       adv;
	logic       room;
	logic       verdict;
	dq_state_t  st_q;
	dq_state_t  st_d;

	// delimiter register, always writable
	assign cfg_ready = 1'b1;
	assign delim_q   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			delim_val_q <= DelimReset;
		else if (delim_q)
			delim_val_q <= delimiter;
	end

	// stage 1 advances unless a verdict has nowhere to go
	assign adv      = v_s1 && (!last_s1 || room);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// scan state update
	ipv4dq_step u_step (
		.st_cur    (st_q),
		.char_code (char_s1),
		.last_char (last_s1),
		.delimiter (delim_val_q),
		.st_next   (st_d),
		.verdict   (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= StateClear;
		else if (adv)
			st_q <= st_d;
	end

	// result register
	ipv4dq_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && last_s1),
		.load_res  (verdict),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.valid_res (valid_res)
	);

	// state is cleared once a string has been judged
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (st_q == StateClear))
		else $error("scan state not cleared after final character");

	// digit count never passes its saturation point
	a_digit_sat: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.digit_count != 2'd3)
		else $error("digit count out of range");

	// tallies of zero and full fields never exceed the closed field count
	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.zero_fields <= st_q.field_count) && (st_q.full_fields <= st_q.field_count))
		else $error("field tally exceeds field count");

	// an empty input stage always takes a word
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty stage");

endmodule

`default_nettype wire

// File: design/ipv4dq_step.sv
// ----------------------------------------------------------------------------
// ipv4dq_step
// Combinational update of the scan state for one character, and the verdict
// when the character ends the string.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_step
	import ipv4dq_pkg::*;
(
	input  wire dq_state_t  st_cur,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	input  wire logic [7:0] delimiter,
	output dq_state_t       st_next,
	output logic            verdict
);

	dq_state_t  st_chr;
	dq_state_t  st_end;
	logic       is_digit;
	logic [3:0] digit;

	assign is_digit = char_code inside {[CharZero:CharNine]};
	assign digit    = 4'(char_code - CharZero);

	// delimiter test takes priority over the digit test
	always_comb begin
		st_chr = st_cur;
		if (char_code == delimiter)
			st_chr = close_field(st_cur);
		else if (is_digit)
			st_chr = take_digit(st_cur, digit);
		else
			st_chr.error_seen = 1'b1;
	end

	// final character closes the open field and judges the string
	always_comb begin
		st_end  = close_field(st_chr);
		verdict = !st_end.error_seen && (st_end.field_count == FieldsNeeded) &&
			(st_end.zero_fields != FieldsNeeded) && (st_end.full_fields != FieldsNeeded);
		st_next = last_char ? StateClear : st_chr;
	end

endmodule

`default_nettype wire

// File: design/ipv4dq_outbuf.sv
// ----------------------------------------------------------------------------
// ipv4dq_outbuf
// Result register with valid/ready toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_outbuf
	import ipv4dq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic load_res,
	output logic      room,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic      valid_res
);

	logic out_valid_q;
	logic res_q;

	// free when empty or being drained this cycle
	assign room = !out_valid_q || out_ready;

	// holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (room)
			out_valid_q <= load;
	end

	// result word
	always_ff @(posedge clk) begin
		if (load && room)
			res_q <= load_res;
	end

	assign out_valid = out_valid_q;
	assign valid_res = res_q;

endmodule

`default_nettype wire
